[hdl/hbpq_pkg.sv]
// ----------------------------------------------------------------------------
// hbpq_pkg
// Shared codes for the binary min-heap priority queue: operation selectors
// and result status values.
// ----------------------------------------------------------------------------
package hbpq_pkg;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

endpackage

[hdl/binary_min_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top
// Min-heap of (key, tag) entries with insert and remove-minimum operations.
// ----------------------------------------------------------------------------
// insert and remove each run from input transfer to result valid; one item is
// worked on at a time
// each heap level needs a registered store read and one key compare on insert, two on remove
// the result register lets the next item enter while a result waits
// reset clears the count and control; the entry store is not cleared
module binary_min_heap_priority_queue_top #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // key, tag
  input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // root_key, root_tag, count, status
  output logic [((KEY_BITS+TAG_BITS+$clog2(DEPTH+1)+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH+1);
  localparam int EW      = KEY_BITS + TAG_BITS;
  localparam int OUT_RAW = EW + CW + 2;

  logic          res_valid;
  logic          res_ready;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CW-1:0] res_count;
  logic [1:0]    res_status;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [EW-1:0] mem_rdata_a;
  logic [EW-1:0] mem_rdata_b;

  logic               out_valid_q;
  logic [OUT_RAW-1:0] out_data_q;

  hbpq_ctrl #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser),
    .key_i         (s_axis_tdata[KEY_BITS-1:0]),
    .tag_i         (s_axis_tdata[EW-1:KEY_BITS]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_key_o     (res_key),
    .res_tag_o     (res_tag),
    .res_count_o   (res_count),
    .res_status_o  (res_status),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  hbpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  // result register frees the sequencer once the transfer is staged
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= {res_status, res_count, res_tag, res_key};
    end
  end

  assign m_axis_tvalid = out_valid_q;

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[OUT_RAW-1:0] = out_data_q;
  end

endmodule

[hdl/hbpq_mem.sv]
// ----------------------------------------------------------------------------
// hbpq_mem
// Heap entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hbpq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hdl/hbpq_ctrl.sv]
// ----------------------------------------------------------------------------
// hbpq_ctrl
// Sift sequencer: walks the heap one level per cycle, holding the moving
// entry in a register and writing it back once its slot is found.
// ----------------------------------------------------------------------------
module hbpq_ctrl #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         func_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [TAG_BITS-1:0]          tag_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [KEY_BITS-1:0]          res_key_o,
  output logic [TAG_BITS-1:0]          res_tag_o,
  output logic [$clog2(DEPTH+1)-1:0]   res_count_o,
  output logic [1:0]                   res_status_o,
  output logic                         mem_we_o,
  output logic [$clog2(DEPTH)-1:0]     mem_waddr_o,
  output logic [KEY_BITS+TAG_BITS-1:0] mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_a_o,
  output logic [$clog2(DEPTH)-1:0]     mem_raddr_b_o,
  input  logic [KEY_BITS+TAG_BITS-1:0] mem_rdata_a_i,
  input  logic [KEY_BITS+TAG_BITS-1:0] mem_rdata_b_i
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int EW = KEY_BITS + TAG_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_DOWN   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    status_q, status_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] par_q, par_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [EW-1:0] root_q;
  logic          accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [AW+1:0] kid_l;
    logic [AW+1:0] kid_r;
    logic [AW+1:0] cnt_w;
    logic [AW+1:0] best;
    logic [AW+1:0] next_l;
    logic          take_l;
    logic          take_r;
    logic [KEY_BITS-1:0] best_key;

    state_d       = state_q;
    count_d       = count_q;
    status_d      = status_q;
    pos_d         = pos_q;
    par_d         = par_q;
    ent_d         = ent_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = ent_q;
    mem_raddr_a_o = par_q;
    mem_raddr_b_o = '0;
    res_valid_o   = 1'b0;

    kid_l    = {1'b0, pos_q, 1'b1};
    kid_r    = kid_l + (AW+2)'(1);
    cnt_w    = (AW+2)'(count_q);
    take_l   = mem_rdata_a_i[KEY_BITS-1:0] < ent_q[KEY_BITS-1:0];
    best_key = take_l ? mem_rdata_a_i[KEY_BITS-1:0] : ent_q[KEY_BITS-1:0];
    take_r   = (kid_r < cnt_w) && (mem_rdata_b_i[KEY_BITS-1:0] < best_key);
    best     = take_r ? kid_r : kid_l;
    next_l   = {1'b0, best[AW-1:0], 1'b1};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ent_d    = {tag_i, key_i};
          status_d = hbpq_pkg::STATUS_OK;
          if (func_i == hbpq_pkg::FUNC_INSERT) begin
            if (count_q == CW'(DEPTH)) begin
              status_d = hbpq_pkg::STATUS_FULL;
              state_d  = S_FINISH;
            end else begin
              count_d = count_q + CW'(1);
              pos_d   = count_q[AW-1:0];
              if (count_q == '0) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = '0;
                mem_wdata_o = {tag_i, key_i};
                state_d     = S_FINISH;
              end else begin
                par_d         = (count_q[AW-1:0] - AW'(1)) >> 1;
                mem_raddr_a_o = par_d;
                state_d       = S_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = hbpq_pkg::STATUS_EMPTY;
              state_d  = S_FINISH;
            end else begin
              count_d       = count_q - CW'(1);
              mem_raddr_a_o = count_d[AW-1:0];
              state_d       = S_LAST;
            end
          end
        end
      end
      S_UP: begin
        mem_we_o = 1'b1;
        if (ent_q[KEY_BITS-1:0] < mem_rdata_a_i[KEY_BITS-1:0]) begin
          // parent drops into the hole, hole moves up
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = par_q;
          if (par_q == '0) begin
            state_d = S_PLACE;
          end else begin
            par_d         = (par_q - AW'(1)) >> 1;
            mem_raddr_a_o = par_d;
          end
        end else begin
          state_d = S_FINISH;
        end
      end
      S_PLACE: begin
        mem_we_o = 1'b1;
        state_d  = S_FINISH;
      end
      S_LAST: begin
        ent_d = mem_rdata_a_i;
        if (count_q == '0) begin
          state_d = S_FINISH;
        end else begin
          pos_d         = '0;
          mem_raddr_a_o = AW'(1);
          mem_raddr_b_o = AW'(2);
          state_d       = S_DOWN;
        end
      end
      S_DOWN: begin
        mem_we_o = 1'b1;
        if (kid_l >= cnt_w || !(take_l || take_r)) begin
          state_d = S_FINISH;
        end else begin
          // smaller child rises into the hole, left wins ties
          mem_wdata_o   = take_r ? mem_rdata_b_i : mem_rdata_a_i;
          pos_d         = best[AW-1:0];
          mem_raddr_a_o = next_l[AW-1:0];
          mem_raddr_b_o = AW'(next_l + (AW+2)'(1));
        end
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= hbpq_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // sift registers, and a shadow copy of slot zero for the result
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    par_q <= par_d;
    ent_q <= ent_d;
    if (mem_we_o && mem_waddr_o == '0) begin
      root_q <= mem_wdata_o;
    end
  end

  assign res_key_o    = (count_q != '0) ? root_q[KEY_BITS-1:0] : '0;
  assign res_tag_o    = (count_q != '0) ? root_q[EW-1:KEY_BITS] : '0;
  assign res_count_o  = count_q;
  assign res_status_o = status_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_q == hbpq_pkg::STATUS_FULL |-> count_q == CW'(DEPTH))
    else $error("full status with room left");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_q == hbpq_pkg::STATUS_EMPTY |-> count_q == '0)
    else $error("empty status with entries held");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !accept) || state_q == S_FINISH |-> !mem_we_o)
    else $error("store written outside a sift");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |=> count_q == $past(count_q))
    else $error("count changed during a sift");
`endif

endmodule

[sim/binary_min_heap_priority_queue_checker.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_checker
// Watches both stream channels of the heap queue. Every accepted operation is
// run through a local copy of the heap to give the expected root, count and
// status, and every accepted result is compared with the oldest of these.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_checker #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32,
  parameter int TAG_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_tvalid_i,
  input  logic in_tready_i,
  // key, tag
  input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] in_tdata_i,
  // func
  input  logic in_tuser_i,
  input  logic out_tvalid_i,
  input  logic out_tready_i,
  // root_key, root_tag, count, status
  input  logic [((KEY_BITS+TAG_BITS+$clog2(DEPTH+1)+2+7)/8)*8-1:0] out_tdata_i,
  output int   fail_count_o,
  output int   pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam int RES_BITS = KEY_BITS + TAG_BITS + CNT_BITS + 2;

  // last field first so the struct lines up with the packed result bus
  typedef struct packed {
    logic [1:0]          status;
    logic [CNT_BITS-1:0] count;
    logic [TAG_BITS-1:0] root_tag;
    logic [KEY_BITS-1:0] root_key;
  } heap_result_t;

  logic [KEY_BITS-1:0] slot_key [DEPTH];
  logic [TAG_BITS-1:0] slot_tag [DEPTH];
  int                  held       = 0;
  int                  mismatches = 0;
  heap_result_t        expected_roots [$];

  function automatic void swap_slots(int a, int b);
    logic [KEY_BITS-1:0] k;
    logic [TAG_BITS-1:0] t;
    k = slot_key[a];
    t = slot_tag[a];
    slot_key[a] = slot_key[b];
    slot_tag[a] = slot_tag[b];
    slot_key[b] = k;
    slot_tag[b] = t;
  endfunction

  function automatic heap_result_t apply_heap_op(logic func, logic [KEY_BITS-1:0] key,
                                                 logic [TAG_BITS-1:0] tag);
    heap_result_t r;
    int pos, parent, lft, rgt, best;
    r.status = hbpq_pkg::STATUS_OK;
    if (func == hbpq_pkg::FUNC_INSERT) begin
      if (held >= DEPTH) begin
        r.status = hbpq_pkg::STATUS_FULL;
      end else begin
        slot_key[held] = key;
        slot_tag[held] = tag;
        pos = held;
        held++;
        // equal keys stop the climb
        while (pos != 0) begin
          parent = (pos - 1) / 2;
          if (slot_key[pos] >= slot_key[parent]) break;
          swap_slots(pos, parent);
          pos = parent;
        end
      end
    end else begin
      if (held == 0) begin
        r.status = hbpq_pkg::STATUS_EMPTY;
      end else begin
        held--;
        if (held != 0) begin
          slot_key[0] = slot_key[held];
          slot_tag[0] = slot_tag[held];
          pos = 0;
          // strict compares: left child wins a tie, parent stays on a tie
          forever begin
            lft  = 2 * pos + 1;
            rgt  = lft + 1;
            best = pos;
            if (lft >= held) break;
            if (slot_key[lft] < slot_key[best]) best = lft;
            if (rgt < held && slot_key[rgt] < slot_key[best]) best = rgt;
            if (best == pos) break;
            swap_slots(pos, best);
            pos = best;
          end
        end
      end
    end
    r.root_key = (held != 0) ? slot_key[0] : '0;
    r.root_tag = (held != 0) ? slot_tag[0] : '0;
    r.count    = held[CNT_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    heap_result_t got;
    if (!rst_ni) begin
      held = 0;
      expected_roots.delete();
    end else begin
      if (in_tvalid_i && in_tready_i) begin
        want = apply_heap_op(in_tuser_i, in_tdata_i[KEY_BITS-1:0],
                             in_tdata_i[KEY_BITS +: TAG_BITS]);
        expected_roots = {expected_roots, want};
      end
      if (out_tvalid_i && out_tready_i) begin
        got = out_tdata_i[RES_BITS-1:0];
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result key=%h tag=%h count=%0d status=%0d",
                     $realtime, got.root_key, got.root_tag, got.count, got.status);
          end
        end else begin
          want = expected_roots.pop_front();
          if (got.root_key !== want.root_key || got.root_tag !== want.root_tag ||
              got.count !== want.count || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch exp key=%h tag=%h count=%0d status=%0d",
                       $realtime, want.root_key, want.root_tag, want.count, want.status);
              $display("%0t:                 got key=%h tag=%h count=%0d status=%0d",
                       $realtime, got.root_key, got.root_tag, got.count, got.status);
            end
          end
        end
      end
    end
    fail_count_o = mismatches;
    pending_o    = expected_roots.size();
  end

endmodule

[sim/binary_min_heap_priority_queue_top_tb.sv]
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_top_tb
// Drives insert and remove operations into the heap queue: a directed opening
// on empty, tie and extreme keys, then fill, drain and mixed runs with random
// keys under several sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int KEY_BITS    = 32;
  localparam int TAG_BITS    = 8;
  localparam int IN_BITS     = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = ((KEY_BITS + TAG_BITS + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8;
  localparam int OPS_PER_PHASE = 375;
  localparam int CYCLE_LIMIT   = 400000;

  logic                clk;
  logic                rst_n    = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata  = '0;
  logic                s_tuser  = hbpq_pkg::FUNC_INSERT;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  int          sender_idle_pct   = 0;
  int          receiver_stall_pct = 0;
  int          fail_count;
  int          pending;
  int unsigned cycle_cnt = 0;

  binary_min_heap_priority_queue_top #(
    .DEPTH   (DEPTH),
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  binary_min_heap_priority_queue_checker #(
    .DEPTH   (DEPTH),
    .KEY_BITS(KEY_BITS),
    .TAG_BITS(TAG_BITS)
  ) u_heap_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_tvalid_i (s_tvalid),
    .in_tready_i (s_tready),
    .in_tdata_i  (s_tdata),
    .in_tuser_i  (s_tuser),
    .out_tvalid_i(m_tvalid),
    .out_tready_i(m_tready),
    .out_tdata_i (m_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // called at a rising edge, returns at the edge of the transfer with tvalid still high
  task automatic send_op(input logic func, input logic [KEY_BITS-1:0] key,
                         input logic [TAG_BITS-1:0] tag);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(IN_BITS - KEY_BITS - TAG_BITS){1'b0}}, tag, key};
    // tready only moves on a rising edge, so the falling edge shows the next sample
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int                  run_left;
    int                  insert_pct;
    logic                func;
    logic [KEY_BITS-1:0] key;

    run_left   = 0;
    insert_pct = 50;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty heap, extremes, ties on both insert and remove
    send_op(hbpq_pkg::FUNC_REMOVE, '1, '1);
    send_op(hbpq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 8'hFF);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0001_0000, 8'h01);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0001_0000, 8'h02);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'h00);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0001_0000, 8'h03);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h8000_0000, 8'h80);
    send_op(hbpq_pkg::FUNC_REMOVE, 32'h1234_5678, 8'h5A);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '1, '1);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'hAA);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'h55);
    send_op(hbpq_pkg::FUNC_INSERT, 32'h0000_0000, 8'h0F);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);
    send_op(hbpq_pkg::FUNC_REMOVE, '0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 81; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 81; end
        default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
      endcase
      for (int i = 0; i < OPS_PER_PHASE; i++) begin
        // fill runs head for full, drain runs for empty and past it, mixed runs insert and remove about equally
        if (run_left == 0) begin
          run_left = $urandom_range(40, 160);
          case ($urandom_range(2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
          endcase
        end
        run_left--;
        func = ($urandom_range(99) < insert_pct) ? hbpq_pkg::FUNC_INSERT
                                                 : hbpq_pkg::FUNC_REMOVE;
        case ($urandom_range(9))
          0:       key = '0;
          1:       key = '1;
          2, 3:    key = $urandom_range(15);
          default: key = $urandom;
        endcase
        send_op(func, key, TAG_BITS'($urandom_range(255)));
      end
    end
    s_tvalid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[binary_min_heap_priority_queue_top.f]
hdl/hbpq_pkg.sv
hdl/hbpq_mem.sv
hdl/hbpq_ctrl.sv
hdl/binary_min_heap_priority_queue_top.sv
sim/binary_min_heap_priority_queue_checker.sv
sim/binary_min_heap_priority_queue_top_tb.sv
